// ===== hdl/ahs_pkg.sv =====
// package: shared types, codes and constants of the axis homing sequencer
`timescale 1ns / 1ps
package ahs_pkg;

  // timing constants, milliseconds
  localparam logic [31:0] ENC_BOOT_DELAY_MS = 32'd2000;
  localparam logic [31:0] ENC_RETRY_MS      = 32'd500;
  localparam logic [31:0] FAULT_RETRY_MS    = 32'd500;
  localparam logic [31:0] POLL_GRACE_MS     = 32'd100;

  // object-dictionary indexes of the homing objects (kept for reference)
  localparam logic [15:0] OD_HOME_STATUS = 16'h2700;
  localparam logic [15:0] OD_FAULT_FLAGS = 16'h2600;
  localparam logic [15:0] OD_HOME_CMD    = 16'h2500;

  // config reset values
  localparam logic        RST_BOOT_AUTOHOME      = 1'b0;
  localparam logic [31:0] RST_NOT_HOMED_MASK     = 32'd1;
  localparam logic [7:0]  RST_STATUS_IDLE_CODE   = 8'd0;
  localparam logic [7:0]  RST_STATUS_DONE_CODE   = 8'd2;
  localparam logic [7:0]  RST_STATUS_FAILED_CODE = 8'd3;
  localparam logic [15:0] RST_POLL_PERIOD_MS     = 16'd200;
  localparam logic [31:0] RST_OVERALL_TIMEOUT_MS = 32'd30000;
  localparam logic [31:0] RST_FAULT_REFRESH_MS   = 32'd5000;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOOT_AUTOHOME      = 3'd0,
    CFG_NOT_HOMED_MASK     = 3'd1,
    CFG_STATUS_IDLE_CODE   = 3'd2,
    CFG_STATUS_DONE_CODE   = 3'd3,
    CFG_STATUS_FAILED_CODE = 3'd4,
    CFG_POLL_PERIOD_MS     = 3'd5,
    CFG_OVERALL_TIMEOUT_MS = 3'd6,
    CFG_FAULT_REFRESH_MS   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_ABORT   = 2'd2,
    OP_REBOOT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BK_NONE        = 3'd0,
    BK_READ_ENC    = 3'd1,
    BK_READ_FAULT  = 3'd2,
    BK_WRITE_CMD0  = 3'd3,
    BK_WRITE_CMD1  = 3'd4,
    BK_READ_STATUS = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ENC    = 3'd1,
    PH_CLEAR  = 3'd2,
    PH_ARM    = 3'd3,
    PH_POLL   = 3'd4,
    PH_FAULT  = 3'd5,
    PH_DONE   = 3'd6,
    PH_FAILED = 3'd7
  } phase_t;

  typedef struct packed {
    logic        boot_autohome;
    logic [31:0] not_homed_mask;
    logic [7:0]  status_idle_code;
    logic [7:0]  status_done_code;
    logic [7:0]  status_failed_code;
    logic [15:0] poll_period_ms;
    logic [31:0] overall_timeout_ms;
    logic [31:0] fault_refresh_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic        link_free;
    logic        reply_ready;
    logic        reply_ok;
    logic [3:0]  reply_len;
    logic [31:0] reply_data;
    logic        grant;
  } in_item_t;

  typedef struct packed {
    logic [2:0] begin_kind;
    logic       request_accepted;
    logic [7:0] status_mirror;
    logic       axis_homed;
    logic       encoder_incremental;
    logic       idle_or_terminal;
    logic [2:0] seq_state;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic        pending;
    logic [31:0] run_start;
    logic [31:0] last_poll;
    logic [7:0]  motor_status;
    logic        homed;
    logic        homed_known;
    logic [31:0] last_fault_read;
    logic        enc_known;
    logic        enc_incremental;
    logic [31:0] last_enc_read;
    logic        boot_home_fired;
  } seq_state_t;

endpackage

// ===== hdl/ahs_in_if.sv =====
// interface: input item channel with valid/ready handshake
`timescale 1ns / 1ps
interface ahs_in_if
  import ahs_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/ahs_out_if.sv =====
// interface: result item channel with valid/ready handshake
`timescale 1ns / 1ps
interface ahs_out_if
  import ahs_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/ahs_cfg_regs.sv =====
// configuration register file of the homing sequencer
`timescale 1ns / 1ps
module ahs_cfg_regs
  import ahs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_autohome      <= RST_BOOT_AUTOHOME;
      cfg.not_homed_mask     <= RST_NOT_HOMED_MASK;
      cfg.status_idle_code   <= RST_STATUS_IDLE_CODE;
      cfg.status_done_code   <= RST_STATUS_DONE_CODE;
      cfg.status_failed_code <= RST_STATUS_FAILED_CODE;
      cfg.poll_period_ms     <= RST_POLL_PERIOD_MS;
      cfg.overall_timeout_ms <= RST_OVERALL_TIMEOUT_MS;
      cfg.fault_refresh_ms   <= RST_FAULT_REFRESH_MS;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOOT_AUTOHOME:      cfg.boot_autohome      <= cfg_data[0];
        CFG_NOT_HOMED_MASK:     cfg.not_homed_mask     <= cfg_data;
        CFG_STATUS_IDLE_CODE:   cfg.status_idle_code   <= cfg_data[7:0];
        CFG_STATUS_DONE_CODE:   cfg.status_done_code   <= cfg_data[7:0];
        CFG_STATUS_FAILED_CODE: cfg.status_failed_code <= cfg_data[7:0];
        CFG_POLL_PERIOD_MS:     cfg.poll_period_ms     <= cfg_data[15:0];
        CFG_OVERALL_TIMEOUT_MS: cfg.overall_timeout_ms <= cfg_data;
        CFG_FAULT_REFRESH_MS:   cfg.fault_refresh_ms   <= cfg_data;
      endcase
    end
  end

endmodule

// ===== hdl/ahs_step.sv =====
// next-state and result logic for one item of the homing sequencer
`timescale 1ns / 1ps
module ahs_step
  import ahs_pkg::*;
(
  input  in_item_t   item,
  input  seq_state_t st,
  input  cfg_t       cfg,
  output seq_state_t st_next,
  output out_item_t  res
);

  always_comb begin
    seq_state_t  s;
    kind_t       kind;
    logic        acc;
    logic        stop;
    logic        go;
    logic [31:0] period;
    logic [31:0] d_enc;
    logic [31:0] d_fault;
    logic [31:0] d_run;
    logic [31:0] d_poll;

    s       = st;
    kind    = BK_NONE;
    acc     = 1'b0;
    stop    = 1'b0;
    go      = 1'b1;
    period  = '0;
    d_enc   = item.now_ms - st.last_enc_read;
    d_fault = '0;
    d_run   = '0;
    d_poll  = '0;

    unique case (op_t'(item.op))
      OP_TICK: begin
        // encoder type read after boot delay, retried until the type is known
        if (s.phase == PH_IDLE && !s.enc_known && item.now_ms >= ENC_BOOT_DELAY_MS) begin
          if ((s.last_enc_read == '0 || d_enc >= ENC_RETRY_MS) && item.link_free) begin
            s.pending       = 1'b1;
            s.phase         = PH_ENC;
            s.last_enc_read = item.now_ms;
            kind            = BK_READ_ENC;
            stop            = 1'b1;
          end
        end
        // once-per-boot auto home
        if (!stop && !s.boot_home_fired && cfg.boot_autohome && s.enc_known
            && s.enc_incremental && s.phase == PH_IDLE && item.grant) begin
          s.motor_status    = cfg.status_idle_code;
          s.phase           = PH_CLEAR;
          s.run_start       = item.now_ms;
          s.last_poll       = '0;
          acc               = 1'b1;
          s.boot_home_fired = 1'b1;
        end
        // fault flag refresh
        if (!stop && s.phase == PH_IDLE) begin
          period  = s.homed_known ? cfg.fault_refresh_ms : FAULT_RETRY_MS;
          d_fault = item.now_ms - s.last_fault_read;
          if ((s.last_fault_read == '0 || d_fault >= period) && item.link_free) begin
            s.pending         = 1'b1;
            s.phase           = PH_FAULT;
            s.last_fault_read = item.now_ms;
            kind              = BK_READ_FAULT;
          end
        end
        // sequence body
        d_run = item.now_ms - s.run_start;
        if (s.phase != PH_IDLE) begin
          if (s.phase != PH_FAULT && s.phase != PH_ENC && d_run > cfg.overall_timeout_ms) begin
            s.phase        = PH_FAILED;
            s.motor_status = cfg.status_failed_code;
          end else begin
            unique case (s.phase)
              PH_ENC: begin
                if (item.reply_ready) begin
                  s.pending = 1'b0;
                  if (item.reply_ok && item.reply_len >= 4'd4) begin
                    s.enc_incremental = (item.reply_data[30:0] != '0);
                    s.enc_known       = 1'b1;
                  end
                  s.phase = PH_IDLE;
                end
              end
              PH_CLEAR, PH_ARM: begin
                if (!s.pending) begin
                  if (!item.link_free) begin
                    go = 1'b0;
                  end else begin
                    kind      = (s.phase == PH_CLEAR) ? BK_WRITE_CMD0 : BK_WRITE_CMD1;
                    s.pending = 1'b1;
                  end
                end
                if (go && item.reply_ready) begin
                  s.pending = 1'b0;
                  if (!item.reply_ok) begin
                    s.phase        = PH_FAILED;
                    s.motor_status = cfg.status_failed_code;
                  end else if (s.phase == PH_CLEAR) begin
                    s.phase = PH_ARM;
                  end else begin
                    s.phase     = PH_POLL;
                    s.last_poll = item.now_ms;
                  end
                end
              end
              PH_POLL: begin
                d_poll = item.now_ms - s.last_poll;
                if (!s.pending) begin
                  if (d_poll < {16'd0, cfg.poll_period_ms} && d_run > POLL_GRACE_MS) begin
                    go = 1'b0;
                  end else if (!item.link_free) begin
                    go = 1'b0;
                  end else begin
                    kind        = BK_READ_STATUS;
                    s.pending   = 1'b1;
                    s.last_poll = item.now_ms;
                  end
                end
                if (go && item.reply_ready) begin
                  s.pending = 1'b0;
                  if (item.reply_ok && item.reply_len != '0) begin
                    s.motor_status = item.reply_data[7:0];
                    if (s.motor_status == cfg.status_done_code
                        || s.motor_status == cfg.status_failed_code) begin
                      s.phase = PH_FAULT;
                    end
                  end
                end
              end
              PH_FAULT: begin
                if (!s.pending) begin
                  if (!item.link_free) begin
                    go = 1'b0;
                  end else begin
                    kind      = BK_READ_FAULT;
                    s.pending = 1'b1;
                  end
                end
                if (go && item.reply_ready) begin
                  s.pending = 1'b0;
                  if (item.reply_ok && item.reply_len >= 4'd4) begin
                    s.homed       = ((item.reply_data & cfg.not_homed_mask) == '0);
                    s.homed_known = 1'b1;
                    // equal done and failed codes: done wins
                    if (s.motor_status == cfg.status_done_code) begin
                      s.phase = PH_DONE;
                    end else if (s.motor_status == cfg.status_failed_code) begin
                      s.phase = PH_FAILED;
                    end else begin
                      s.phase = PH_IDLE;
                    end
                  end else begin
                    s.phase = PH_IDLE;
                  end
                end
              end
              default: s.phase = PH_IDLE;
            endcase
          end
        end
      end
      OP_REQUEST: begin
        if (item.grant && s.phase == PH_IDLE) begin
          s.motor_status = cfg.status_idle_code;
          s.phase        = PH_CLEAR;
          s.run_start    = item.now_ms;
          s.last_poll    = '0;
          acc            = 1'b1;
        end
      end
      OP_ABORT: begin
        // pending is left as is
        if (item.link_free) begin
          kind = BK_WRITE_CMD0;
        end
        s.phase        = PH_IDLE;
        s.motor_status = cfg.status_idle_code;
      end
      OP_REBOOT: begin
        s.phase        = PH_IDLE;
        s.pending      = 1'b0;
        s.motor_status = cfg.status_idle_code;
      end
    endcase

    st_next                 = s;
    res.begin_kind          = kind;
    res.request_accepted    = acc;
    res.status_mirror       = s.motor_status;
    res.axis_homed          = s.homed_known & s.homed;
    res.encoder_incremental = !s.enc_known | s.enc_incremental;
    res.idle_or_terminal    = (s.phase == PH_IDLE) || (s.phase == PH_DONE)
                              || (s.phase == PH_FAILED);
    res.seq_state           = s.phase;
  end

endmodule

// ===== hdl/axis_homing_sequencer.sv =====
// top level: axis homing sequencer with registered input and result stages
`timescale 1ns / 1ps
// an accepted item is held in the input register, then its result in the result register until taken
// throughput: one item per cycle, held back only while the result register is full and not taken
// the sequencer state updates in the cycle the item leaves the input register
// reset (rst, synchronous, active high): sequencer idle, all flags and timestamps zero,
// config registers back to their defaults, both pipeline stages empty
module axis_homing_sequencer
  import ahs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  ahs_in_if.sink                 in_ch,
  ahs_out_if.source              out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;

  // input register stage
  logic       in_valid;
  logic       in_valid_next;
  in_item_t   in_item;

  // sequencer state
  seq_state_t st;
  seq_state_t st_next;

  // result register stage
  logic       out_valid;
  logic       out_valid_next;
  out_item_t  result;
  out_item_t  res_comb;

  logic       take;     // item accepted from the input channel
  logic       advance;  // item processed into the result register

  ahs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahs_step u_step (
    .item    (in_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res_comb)
  );

  // the item moves on whenever the result register is free or drains this cycle
  assign advance        = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready    = !in_valid || advance;
  assign take           = in_ch.valid && in_ch.ready;
  assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid);
  assign out_valid_next = advance ? 1'b1 : (out_valid && !out_ch.ready);

  assign out_ch.valid = out_valid;
  assign out_ch.item  = result;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= in_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= in_ch.item;
    end
    if (advance) begin
      result <= res_comb;
    end
  end

  // sequencer state, one update per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_IDLE;
      st.pending         <= 1'b0;
      st.run_start       <= '0;
      st.last_poll       <= '0;
      st.motor_status    <= '0;
      st.homed           <= 1'b0;
      st.homed_known     <= 1'b0;
      st.last_fault_read <= '0;
      st.enc_known       <= 1'b0;
      st.enc_incremental <= 1'b0;
      st.last_enc_read   <= '0;
      st.boot_home_fired <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // state moves only when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("sequencer state changed without an item");

  // an empty result register never stalls the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled while result register empty");

  // an encoder read leaves the sequencer in encoder read or back at idle
  a_enc_read_phase: assert property (@(posedge clk) disable iff (rst)
    (advance && res_comb.begin_kind == BK_READ_ENC)
      |-> (res_comb.seq_state == PH_ENC || res_comb.seq_state == PH_IDLE))
    else $error("encoder read issued from wrong phase");

endmodule

// ===== sim/axis_homing_sequencer_checker.sv =====
// checker: predicts each status item of the homing sequencer and compares the results
`timescale 1ns / 1ps
module axis_homing_sequencer_checker
  import ahs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  cfg_t        regs;
  phase_t      seq_phase;
  logic        xact_open;
  logic [31:0] run_start_ms;
  logic [31:0] last_poll_ms;
  logic [7:0]  motor_code;
  logic        homed;
  logic        homed_known;
  logic [31:0] fault_read_ms;
  logic        enc_known;
  logic        enc_incremental;
  logic [31:0] enc_read_ms;
  logic        boot_homed;

  out_item_t   status_due[$];
  out_item_t   want;
  int          miss_count = 0;
  int          result_no = 0;

  assign mismatches = miss_count;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    miss_count++;
    $display("mismatch on result %0d: %s got %0h want %0h", result_no, what, got, exp_val);
  endtask

  function automatic logic try_start(logic [31:0] now, logic grant);
    if (!grant || seq_phase != PH_IDLE) return 1'b0;
    motor_code   = regs.status_idle_code;
    seq_phase    = PH_CLEAR;
    run_start_ms = now;
    last_poll_ms = 32'd0;
    return 1'b1;
  endfunction

  function automatic void run_failed();
    seq_phase  = PH_FAILED;
    motor_code = regs.status_failed_code;
  endfunction

  // idle-time work on a tick: encoder probe, boot homing, fault refresh
  function automatic kind_t tick_launch(in_item_t it, output logic took);
    logic [31:0] now;
    logic        due;
    took = 1'b0;
    now  = it.now_ms;
    if (seq_phase == PH_IDLE && !enc_known && now >= ENC_BOOT_DELAY_MS) begin
      due = (enc_read_ms == 32'd0) || ((now - enc_read_ms) >= ENC_RETRY_MS);
      if (due && it.link_free) begin
        xact_open   = 1'b1;
        seq_phase   = PH_ENC;
        enc_read_ms = now;
        return BK_READ_ENC;
      end
    end
    if (!boot_homed && regs.boot_autohome && enc_known && enc_incremental
        && seq_phase == PH_IDLE) begin
      if (try_start(now, it.grant)) begin
        took       = 1'b1;
        boot_homed = 1'b1;
      end
    end
    if (seq_phase == PH_IDLE) begin
      due = (fault_read_ms == 32'd0) ||
            ((now - fault_read_ms) >= (homed_known ? regs.fault_refresh_ms : FAULT_RETRY_MS));
      if (due && it.link_free) begin
        xact_open     = 1'b1;
        seq_phase     = PH_FAULT;
        fault_read_ms = now;
        return BK_READ_FAULT;
      end
    end
    return BK_NONE;
  endfunction

  // one step of the running sequence
  function automatic kind_t advance_run(in_item_t it, kind_t kind);
    logic [31:0] now;
    kind_t       k;
    now = it.now_ms;
    k   = kind;
    if (seq_phase == PH_IDLE) return k;
    if (seq_phase != PH_FAULT && seq_phase != PH_ENC
        && (now - run_start_ms) > regs.overall_timeout_ms) begin
      run_failed();
      return k;
    end
    case (seq_phase)
      PH_ENC: begin
        if (!it.reply_ready) return k;
        xact_open = 1'b0;
        if (it.reply_ok && it.reply_len >= 4'd4) begin
          enc_incremental = (it.reply_data[30:0] != 31'd0);
          enc_known       = 1'b1;
        end
        seq_phase = PH_IDLE;
      end
      PH_CLEAR, PH_ARM: begin
        if (!xact_open) begin
          if (!it.link_free) return k;
          k = (seq_phase == PH_CLEAR) ? BK_WRITE_CMD0 : BK_WRITE_CMD1;
          xact_open = 1'b1;
        end
        if (!it.reply_ready) return k;
        xact_open = 1'b0;
        if (!it.reply_ok) run_failed();
        else if (seq_phase == PH_CLEAR) seq_phase = PH_ARM;
        else begin
          seq_phase    = PH_POLL;
          last_poll_ms = now;
        end
      end
      PH_POLL: begin
        if (!xact_open) begin
          if ((now - last_poll_ms) < {16'd0, regs.poll_period_ms}
              && (now - run_start_ms) > POLL_GRACE_MS) return k;
          if (!it.link_free) return k;
          k            = BK_READ_STATUS;
          xact_open    = 1'b1;
          last_poll_ms = now;
        end
        if (!it.reply_ready) return k;
        xact_open = 1'b0;
        if (!it.reply_ok || it.reply_len == 4'd0) return k;
        motor_code = it.reply_data[7:0];
        if (motor_code == regs.status_done_code || motor_code == regs.status_failed_code)
          seq_phase = PH_FAULT;
      end
      PH_FAULT: begin
        if (!xact_open) begin
          if (!it.link_free) return k;
          k         = BK_READ_FAULT;
          xact_open = 1'b1;
        end
        if (!it.reply_ready) return k;
        xact_open = 1'b0;
        if (it.reply_ok && it.reply_len >= 4'd4) begin
          homed       = ((it.reply_data & regs.not_homed_mask) == 32'd0);
          homed_known = 1'b1;
          if (motor_code == regs.status_done_code) seq_phase = PH_DONE;
          else if (motor_code == regs.status_failed_code) seq_phase = PH_FAILED;
          else seq_phase = PH_IDLE;
        end else begin
          seq_phase = PH_IDLE;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    return k;
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    kind_t     kind;
    logic      accepted;
    out_item_t r;
    kind     = BK_NONE;
    accepted = 1'b0;
    case (it.op)
      OP_TICK: begin
        kind = tick_launch(it, accepted);
        kind = advance_run(it, kind);
      end
      OP_REQUEST: accepted = try_start(it.now_ms, it.grant);
      OP_ABORT: begin
        if (it.link_free) kind = BK_WRITE_CMD0;
        seq_phase  = PH_IDLE;
        motor_code = regs.status_idle_code;
      end
      default: begin
        seq_phase  = PH_IDLE;
        xact_open  = 1'b0;
        motor_code = regs.status_idle_code;
      end
    endcase
    r.begin_kind          = kind;
    r.request_accepted    = accepted;
    r.status_mirror       = motor_code;
    r.axis_homed          = homed_known && homed;
    r.encoder_incremental = !enc_known || enc_incremental;
    r.idle_or_terminal    = (seq_phase == PH_IDLE) || (seq_phase == PH_DONE)
                            || (seq_phase == PH_FAILED);
    r.seq_state           = seq_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.boot_autohome      = RST_BOOT_AUTOHOME;
      regs.not_homed_mask     = RST_NOT_HOMED_MASK;
      regs.status_idle_code   = RST_STATUS_IDLE_CODE;
      regs.status_done_code   = RST_STATUS_DONE_CODE;
      regs.status_failed_code = RST_STATUS_FAILED_CODE;
      regs.poll_period_ms     = RST_POLL_PERIOD_MS;
      regs.overall_timeout_ms = RST_OVERALL_TIMEOUT_MS;
      regs.fault_refresh_ms   = RST_FAULT_REFRESH_MS;
      seq_phase       = PH_IDLE;
      xact_open       = 1'b0;
      run_start_ms    = 32'd0;
      last_poll_ms    = 32'd0;
      motor_code      = 8'd0;
      homed           = 1'b0;
      homed_known     = 1'b0;
      fault_read_ms   = 32'd0;
      enc_known       = 1'b0;
      enc_incremental = 1'b0;
      enc_read_ms     = 32'd0;
      boot_homed      = 1'b0;
      status_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BOOT_AUTOHOME:      regs.boot_autohome      = cfg_data[0];
          CFG_NOT_HOMED_MASK:     regs.not_homed_mask     = cfg_data;
          CFG_STATUS_IDLE_CODE:   regs.status_idle_code   = cfg_data[7:0];
          CFG_STATUS_DONE_CODE:   regs.status_done_code   = cfg_data[7:0];
          CFG_STATUS_FAILED_CODE: regs.status_failed_code = cfg_data[7:0];
          CFG_POLL_PERIOD_MS:     regs.poll_period_ms     = cfg_data[15:0];
          CFG_OVERALL_TIMEOUT_MS: regs.overall_timeout_ms = cfg_data;
          default:                regs.fault_refresh_ms   = cfg_data;
        endcase
      end
      if (in_valid && in_ready)
        status_due.push_back(predict_status(in_item));
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("item with nothing expected", 32'(out_item), 32'd0);
        end else begin
          want = status_due.pop_front();
          if (out_item.begin_kind !== want.begin_kind)
            report_mismatch("begin_kind", 32'(out_item.begin_kind), 32'(want.begin_kind));
          if (out_item.request_accepted !== want.request_accepted)
            report_mismatch("request_accepted", 32'(out_item.request_accepted),
                            32'(want.request_accepted));
          if (out_item.status_mirror !== want.status_mirror)
            report_mismatch("status_mirror", 32'(out_item.status_mirror),
                            32'(want.status_mirror));
          if (out_item.axis_homed !== want.axis_homed)
            report_mismatch("axis_homed", 32'(out_item.axis_homed), 32'(want.axis_homed));
          if (out_item.encoder_incremental !== want.encoder_incremental)
            report_mismatch("encoder_incremental", 32'(out_item.encoder_incremental),
                            32'(want.encoder_incremental));
          if (out_item.idle_or_terminal !== want.idle_or_terminal)
            report_mismatch("idle_or_terminal", 32'(out_item.idle_or_terminal),
                            32'(want.idle_or_terminal));
          if (out_item.seq_state !== want.seq_state)
            report_mismatch("seq_state", 32'(out_item.seq_state), 32'(want.seq_state));
        end
        result_no++;
      end
    end
    outstanding <= status_due.size();
  end

endmodule

// ===== sim/axis_homing_sequencer_test.sv =====
// testbench top: stimulus, flow control and verdict for the axis homing sequencer
`timescale 1ns / 1ps
module axis_homing_sequencer_test;
  import ahs_pkg::*;

  // generous cycle cap: ~670 items, with random idle cycles on both sides
  localparam int LIMIT   = 400000;
  // item count at which the receiver starts its long hold-off
  localparam int HOLD_AT = 420;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ahs_in_if  in_ch ();
  ahs_out_if out_ch ();

  int          mismatches;
  int          outstanding;
  int          cycles    = 0;
  int          sent      = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  bit          calm      = 1'b0;   // no idling on either side while set
  cfg_t        cur;                // register values currently loaded
  cfg_t        plan;
  logic [31:0] clock_ms;           // millisecond time carried by the items
  logic [31:0] enc_word;           // encoder type word of the directed part

  axis_homing_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  axis_homing_sequencer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_ch.item),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_item    (out_ch.item),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run cap
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, none while calm, and one long hold-off so that
  // both pipeline stages fill and the input side gets stalled
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!held_once && sent >= HOLD_AT) begin
      held_once    <= 1'b1;
      hold_left    <= 90;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  function automatic in_item_t make_item(op_t op, logic [31:0] now, logic lf, logic rdy,
                                         logic ok, logic [3:0] len, logic [31:0] data,
                                         logic grant);
    in_item_t it;
    it.op          = op;
    it.now_ms      = now;
    it.link_free   = lf;
    it.reply_ready = rdy;
    it.reply_ok    = ok;
    it.reply_len   = len;
    it.reply_data  = data;
    it.grant       = grant;
    return it;
  endfunction

  // offer one item, with random idle cycles ahead of it, and wait for the handshake
  task automatic offer(in_item_t it);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // wait for the sequencer to go quiet, then write every register
  task automatic load_settings(cfg_t s);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // the result register may still be emptying, so wait before the writes
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_BOOT_AUTOHOME;
    cfg_data  <= {31'd0, s.boot_autohome};
    @(posedge clk);
    cfg_index <= CFG_NOT_HOMED_MASK;
    cfg_data  <= s.not_homed_mask;
    @(posedge clk);
    cfg_index <= CFG_STATUS_IDLE_CODE;
    cfg_data  <= {24'd0, s.status_idle_code};
    @(posedge clk);
    cfg_index <= CFG_STATUS_DONE_CODE;
    cfg_data  <= {24'd0, s.status_done_code};
    @(posedge clk);
    cfg_index <= CFG_STATUS_FAILED_CODE;
    cfg_data  <= {24'd0, s.status_failed_code};
    @(posedge clk);
    cfg_index <= CFG_POLL_PERIOD_MS;
    cfg_data  <= {16'd0, s.poll_period_ms};
    @(posedge clk);
    cfg_index <= CFG_OVERALL_TIMEOUT_MS;
    cfg_data  <= s.overall_timeout_ms;
    @(posedge clk);
    cfg_index <= CFG_FAULT_REFRESH_MS;
    cfg_data  <= s.fault_refresh_ms;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur = s;
  endtask

  // random items: mostly ticks with plausible replies so homing runs get
  // through clear, arm, poll and fault read; requests, aborts and reboots mixed in
  task automatic run_phase(int count);
    in_item_t it;
    int       r;
    int       n;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 78) it.op = OP_TICK;
      else if (r < 90) it.op = OP_REQUEST;
      else if (r < 95) it.op = OP_ABORT;
      else it.op = OP_REBOOT;

      // mostly small time steps, some long ones for refresh and timeout,
      // rare jumps anywhere so the time wraps
      r = $urandom_range(99);
      if (r < 70) clock_ms = clock_ms + $urandom_range(0, 60);
      else if (r < 92) clock_ms = clock_ms + $urandom_range(60, 400);
      else if (r < 99) clock_ms = clock_ms + $urandom_range(400, 8000);
      else clock_ms = $urandom;
      it.now_ms = clock_ms;

      it.link_free   = ($urandom_range(99) < 85);
      it.reply_ready = ($urandom_range(99) < 80);
      it.reply_ok    = ($urandom_range(99) < 90);
      if ($urandom_range(99) < 75) it.reply_len = 4'($urandom_range(4, 8));
      else it.reply_len = 4'($urandom_range(0, 8));

      // reply word: status codes in the low byte, zero and sign-only words
      // for the encoder and fault tests, or anything
      it.reply_data = $urandom;
      r = $urandom_range(99);
      if (r < 25) it.reply_data[7:0] = cur.status_done_code;
      else if (r < 45) it.reply_data[7:0] = cur.status_failed_code;
      else if (r < 55) it.reply_data[7:0] = cur.status_idle_code;
      else if (r < 65) it.reply_data = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'd0;

      it.grant = ($urandom_range(99) < 90);
      offer(it);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_BOOT_AUTOHOME;
    cfg_data    <= 32'd0;
    // sign bit only reads as absolute, any set bit below it as incremental
    enc_word = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h8000_0100;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, register defaults
    // fault read started at time zero, so the stamp still counts as never
    offer(make_item(OP_TICK, 32'd0, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd10, 1'b1, 1'b1, 1'b1, 4'd4, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd20, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    // failed fault read
    offer(make_item(OP_TICK, 32'd30, 1'b1, 1'b1, 1'b0, 4'd4, 32'd0, 1'b1));
    // encoder probe after the boot delay, short reply, retry not yet due, retry
    offer(make_item(OP_TICK, 32'd2000, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2010, 1'b1, 1'b1, 1'b1, 4'd3, enc_word, 1'b1));
    offer(make_item(OP_TICK, 32'd2100, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2500, 1'b1, 1'b1, 1'b1, 4'd8, enc_word, 1'b1));
    // request without grant, accepted request, request while busy
    offer(make_item(OP_REQUEST, 32'd2600, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0));
    offer(make_item(OP_REQUEST, 32'd2600, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_REQUEST, 32'd2605, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    // clear with link busy, clear, arm, poll inside the grace window with empty reply
    offer(make_item(OP_TICK, 32'd2610, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2620, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2630, 1'b0, 1'b1, 1'b1, 4'd4, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2640, 1'b1, 1'b1, 1'b1, 4'd4, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd2650, 1'b1, 1'b1, 1'b1, 4'd0, 32'd0, 1'b1));
    // done status, fault read with not-homed bit, done goes back to idle
    offer(make_item(OP_TICK, 32'd2900, 1'b1, 1'b1, 1'b1, 4'd1, 32'hABCD_EF02, 1'b1));
    offer(make_item(OP_TICK, 32'd2910, 1'b1, 1'b1, 1'b1, 4'd4, 32'h0000_0001, 1'b1));
    offer(make_item(OP_TICK, 32'd2920, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    // abort of a run, reboot with a command outstanding, abort with link busy
    offer(make_item(OP_REQUEST, 32'd3000, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_ABORT, 32'd3010, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_REQUEST, 32'd3100, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd3110, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_REBOOT, 32'd3120, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_ABORT, 32'd3130, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    // overall timeout, then abort out of the failed state
    offer(make_item(OP_REQUEST, 32'd40000, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_TICK, 32'd80000, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    offer(make_item(OP_ABORT, 32'd80010, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1));
    clock_ms = 32'd80100;

    // boot homing on, short timeout and refresh
    plan.boot_autohome      = 1'b1;
    plan.not_homed_mask     = 32'h0000_0005;
    plan.status_idle_code   = 8'd0;
    plan.status_done_code   = 8'd2;
    plan.status_failed_code = 8'd3;
    plan.poll_period_ms     = 16'd40;
    plan.overall_timeout_ms = 32'd2500;
    plan.fault_refresh_ms   = 32'd1500;
    load_settings(plan);
    run_phase(160);

    // low extremes, done and failed codes equal
    plan.boot_autohome      = 1'b0;
    plan.not_homed_mask     = 32'hFFFF_FFFF;
    plan.status_idle_code   = 8'd0;
    plan.status_done_code   = 8'd255;
    plan.status_failed_code = 8'd255;
    plan.poll_period_ms     = 16'd0;
    plan.overall_timeout_ms = 32'd0;
    plan.fault_refresh_ms   = 32'd0;
    load_settings(plan);
    calm = 1'b1;
    run_phase(80);
    calm = 1'b0;
    run_phase(80);

    // high extremes; the receiver hold-off lands in this phase
    plan.boot_autohome      = 1'b1;
    plan.not_homed_mask     = 32'd0;
    plan.status_idle_code   = 8'd255;
    plan.status_done_code   = 8'd0;
    plan.status_failed_code = 8'd128;
    plan.poll_period_ms     = 16'hFFFF;
    plan.overall_timeout_ms = 32'hFFFF_FFFF;
    plan.fault_refresh_ms   = 32'hFFFF_FFFF;
    load_settings(plan);
    run_phase(160);

    // random mid-range settings
    plan.boot_autohome      = 1'($urandom_range(1));
    plan.not_homed_mask     = $urandom;
    plan.status_idle_code   = 8'($urandom_range(0, 7));
    plan.status_done_code   = 8'($urandom_range(0, 7));
    plan.status_failed_code = 8'($urandom_range(0, 7));
    plan.poll_period_ms     = 16'($urandom_range(0, 300));
    plan.overall_timeout_ms = $urandom_range(500, 20000);
    plan.fault_refresh_ms   = $urandom_range(0, 8000);
    load_settings(plan);
    run_phase(160);

    // drain: wait until every expected item is back, then give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
